/* sv/gbn_receiver_connection_fsm_unit_macros.svh */
// assertion macros for the go-back-n receiver connection unit
`ifndef GBN_RECEIVER_CONNECTION_FSM_UNIT_MACROS_SVH
`define GBN_RECEIVER_CONNECTION_FSM_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define GCF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define GCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/gcf_pkg.sv */
// shared types and constants of the go-back-n receiver connection unit
package gcf_pkg;

	localparam int SEQ_MODULUS_DEF    = 25601;
	localparam int WINDOW_PACKETS_DEF = 10;
	localparam int PAYLOAD_MAX_DEF    = 512;
	localparam int QUEUE_DEPTH_DEF    = 8;

	localparam int SEQ_W    = 15;
	localparam int NUM_W    = 16;
	localparam int LEN_W    = 10;
	localparam int TICK_W   = 16;
	localparam int RED_W    = 17;
	localparam int RECIP_SH = 17;
	localparam int MAX_RES  = 3;
	localparam int RIDX_W   = 2;
	localparam int CNT_W    = 2;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd500;
	localparam logic [SEQ_W-1:0]  INIT_SEQ_RST = 15'd0;

	localparam logic REG_INIT_SEQ = 1'b0;
	localparam logic REG_TIMEOUT  = 1'b1;

	typedef enum logic [1:0] {
		PH_WAIT_SYN  = 2'd0,
		PH_HANDSHAKE = 2'd1,
		PH_DATA      = 2'd2,
		PH_CLOSING   = 2'd3
	} phase_t;

	typedef struct packed {
		logic             mode;
		logic [NUM_W-1:0] seq;
		logic [NUM_W-1:0] ack;
		logic             syn;
		logic             fin;
		logic             ackf;
		logic             dup;
		logic [LEN_W-1:0] len;
		logic [SEQ_W-1:0] init_seq;
		logic [SEQ_W-1:0] s_inc;
		logic [SEQ_W-1:0] s_len;
		logic [SEQ_W-1:0] init_inc;
	} item_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] ack;
		logic             syn;
		logic             fin;
		logic             ackf;
		logic             dup;
		logic             resend;
		logic             tmo;
		logic             store;
		logic [LEN_W-1:0] bytes;
	} res_t;

endpackage

/* sv/gcf_mod_reduce.sv */
// pipelined reduction modulo the sequence modulus by reciprocal multiply
module gcf_mod_reduce
	import gcf_pkg::*;
#(
	parameter int MODULUS = SEQ_MODULUS_DEF
) (
	input  logic             clk,
	input  logic [RED_W-1:0] x,
	output logic [SEQ_W-1:0] r
);

	localparam logic [RED_W-1:0] RECIP = RED_W'((64'd1 << RECIP_SH) / MODULUS);
	localparam logic [RED_W-1:0] MOD_R = RED_W'(MODULUS);

	logic [2*RED_W-1:0] prod_s1;
	logic [RED_W-1:0]   x_s1;
	logic [RED_W-1:0]   qm_s2;
	logic [RED_W-1:0]   x_s2;
	logic [SEQ_W-1:0]   r_s3;
	logic [2*RED_W-1:0] qm_full;
	logic [RED_W-1:0]   diff;

	assign qm_full = prod_s1[2*RED_W-1:RECIP_SH] * MOD_R;
	assign diff    = x_s2 - qm_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= x * RECIP;
		x_s1    <= x;
		qm_s2   <= qm_full[RED_W-1:0];
		x_s2    <= x_s1;
		if (diff >= MOD_R) begin
			r_s3 <= SEQ_W'(diff - MOD_R);
		end else begin
			r_s3 <= SEQ_W'(diff);
		end
	end

	assign r = r_s3;

endmodule

/* sv/gcf_front.sv */
// front end: accepts requests, clamps length and reduces sequence sums
module gcf_front
	import gcf_pkg::*;
#(
	parameter int MODULUS     = SEQ_MODULUS_DEF,
	parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
	parameter int DEPTH       = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  logic [IN_DATA_W-1:0] s_data,
	input  logic                 s_mode,
	input  logic [SEQ_W-1:0]     initial_seq,
	input  logic                 q_pop,
	output logic                 q_push,
	output item_t                q_item
);

	localparam int CRED_W = $clog2(DEPTH + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PAYLOAD_MAX);

	logic              accept;
	logic [NUM_W-1:0]  pkt_seq;
	logic [LEN_W-1:0]  len_raw;
	logic [LEN_W-1:0]  len_c;
	logic [RED_W-1:0]  x_inc;
	logic [RED_W-1:0]  x_len;
	logic [RED_W-1:0]  x_init;
	logic [SEQ_W-1:0]  r_inc;
	logic [SEQ_W-1:0]  r_len;
	logic [SEQ_W-1:0]  r_init;
	item_t             fld_in;
	item_t             fld_s1;
	item_t             fld_s2;
	item_t             fld_s3;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic [CRED_W-1:0] cred_q;

	assign s_ready = cred_q < CRED_W'(DEPTH);
	assign accept  = s_valid && s_ready;

	assign pkt_seq = s_data[15:0];
	assign len_raw = s_data[45:36];
	assign len_c   = (len_raw > LEN_MAX) ? LEN_MAX : len_raw;

	assign x_inc  = {1'b0, pkt_seq} + RED_W'(1);
	assign x_len  = {1'b0, pkt_seq} + RED_W'(len_c);
	assign x_init = RED_W'(initial_seq) + RED_W'(1);

	always_comb begin
		fld_in          = '0;
		fld_in.mode     = s_mode;
		fld_in.seq      = pkt_seq;
		fld_in.ack      = s_data[31:16];
		fld_in.syn      = s_data[32];
		fld_in.fin      = s_data[33];
		fld_in.ackf     = s_data[34];
		fld_in.dup      = s_data[35];
		fld_in.len      = len_c;
		fld_in.init_seq = initial_seq;
	end

	gcf_mod_reduce #(.MODULUS(MODULUS)) u_red_inc (.clk(clk), .x(x_inc), .r(r_inc));
	gcf_mod_reduce #(.MODULUS(MODULUS)) u_red_len (.clk(clk), .x(x_len), .r(r_len));
	gcf_mod_reduce #(.MODULUS(MODULUS)) u_red_init (.clk(clk), .x(x_init), .r(r_init));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			cred_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (accept && !q_pop) begin
				cred_q <= cred_q + CRED_W'(1);
			end else if (!accept && q_pop) begin
				cred_q <= cred_q - CRED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		fld_s1 <= fld_in;
		fld_s2 <= fld_s1;
		fld_s3 <= fld_s2;
	end

	always_comb begin
		q_item          = fld_s3;
		q_item.s_inc    = r_inc;
		q_item.s_len    = r_len;
		q_item.init_inc = r_init;
	end

	assign q_push = v_s3;

endmodule

/* sv/gcf_queue.sv */
// request queue between front end and connection state machine
module gcf_queue
	import gcf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  valid,
	output logic  full,
	output item_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign valid = cnt_q != '0;
	assign full  = cnt_q == CW'(DEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* sv/gcf_back.sv */
// back end: connection state machine and response header serializer
module gcf_back
	import gcf_pkg::*;
#(
	parameter int MODULUS        = SEQ_MODULUS_DEF,
	parameter int WINDOW_PACKETS = WINDOW_PACKETS_DEF,
	parameter int PAYLOAD_MAX    = PAYLOAD_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	input  logic [TICK_W-1:0] timeout_ticks,
	output logic              m_valid,
	input  logic              m_ready,
	output res_t              m_res,
	output logic              m_last
);

	localparam logic [NUM_W-1:0] MOD_N    = NUM_W'(MODULUS);
	localparam logic [SEQ_W-1:0] MOD_M1   = SEQ_W'(MODULUS - 1);
	localparam logic [NUM_W-1:0] WIN_SPAN = NUM_W'(WINDOW_PACKETS * PAYLOAD_MAX);

	phase_t            phase_q;
	phase_t            phase_d;
	logic [SEQ_W-1:0]  own_seq_q;
	logic [SEQ_W-1:0]  own_seq_d;
	logic [SEQ_W-1:0]  own_inc_q;
	logic [SEQ_W-1:0]  own_inc_d;
	logic [SEQ_W-1:0]  peer_q;
	logic [SEQ_W-1:0]  peer_d;
	logic [TICK_W-1:0] retx_q;
	logic [TICK_W-1:0] retx_d;
	res_t              res_q [MAX_RES];
	res_t              res_d [MAX_RES];
	logic [CNT_W-1:0]  n_res;
	logic [CNT_W-1:0]  rcnt_q;
	logic [RIDX_W-1:0] ridx_q;

	logic              load_ok;
	logic              seq_match;
	logic              ack_ok;
	logic [NUM_W-1:0]  peer_p1;
	logic [NUM_W-1:0]  slen_p1;
	logic [NUM_W-1:0]  a_p1;
	logic [SEQ_W-1:0]  peer_inc;
	logic [SEQ_W-1:0]  slen_inc;
	logic [SEQ_W-1:0]  a_inc;
	logic [SEQ_W-1:0]  s_mod;
	logic [NUM_W-1:0]  ahead;
	logic [SEQ_W-1:0]  fin_ack;

	assign load_ok = (rcnt_q == '0) || ((rcnt_q == CNT_W'(1)) && m_ready);
	assign q_pop   = q_valid && load_ok;

	assign seq_match = q_item.seq == {1'b0, peer_q};
	assign ack_ok    = (q_item.ackf || q_item.dup) && (q_item.ack == {1'b0, own_inc_q});

	assign peer_p1  = {1'b0, peer_q} + NUM_W'(1);
	assign slen_p1  = {1'b0, q_item.s_len} + NUM_W'(1);
	assign a_p1     = {1'b0, q_item.ack[SEQ_W-1:0]} + NUM_W'(1);
	assign peer_inc = (peer_p1 == MOD_N) ? '0 : peer_p1[SEQ_W-1:0];
	assign slen_inc = (slen_p1 == MOD_N) ? '0 : slen_p1[SEQ_W-1:0];
	assign a_inc    = (a_p1 == MOD_N) ? '0 : a_p1[SEQ_W-1:0];
	assign s_mod    = (q_item.s_inc == '0) ? MOD_M1 : q_item.s_inc - SEQ_W'(1);
	assign ahead    = (s_mod >= peer_q) ? NUM_W'(s_mod - peer_q)
	                                    : NUM_W'(s_mod) + MOD_N - NUM_W'(peer_q);
	assign fin_ack  = seq_match ? slen_inc : peer_inc;

	always_comb begin
		phase_d = phase_q;
		if (q_pop && !q_item.mode) begin
			case (phase_q)
				PH_WAIT_SYN: begin
					if (q_item.syn) begin
						phase_d = PH_HANDSHAKE;
					end
				end
				PH_HANDSHAKE: begin
					if (seq_match && ack_ok) begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					if (q_item.fin) begin
						phase_d = PH_CLOSING;
					end
				end
				PH_CLOSING: begin
					if (!q_item.fin && ack_ok) begin
						phase_d = PH_WAIT_SYN;
					end
				end
				default: phase_d = PH_WAIT_SYN;
			endcase
		end
	end

	always_comb begin
		own_seq_d = own_seq_q;
		own_inc_d = own_inc_q;
		peer_d    = peer_q;
		retx_d    = retx_q;
		n_res     = '0;
		for (int k = 0; k < MAX_RES; k++) begin
			res_d[k]     = '0;
			res_d[k].seq = own_seq_q;
		end
		if (q_item.mode) begin
			if (phase_q == PH_CLOSING) begin
				if (retx_q <= TICK_W'(1)) begin
					res_d[0].fin    = 1'b1;
					res_d[0].resend = 1'b1;
					res_d[0].tmo    = 1'b1;
					n_res           = CNT_W'(1);
					retx_d          = timeout_ticks;
				end else begin
					retx_d = retx_q - TICK_W'(1);
				end
			end
		end else begin
			case (phase_q)
				PH_WAIT_SYN: begin
					if (q_item.syn) begin
						own_seq_d     = q_item.init_seq;
						own_inc_d     = q_item.init_inc;
						peer_d        = q_item.s_inc;
						res_d[0].seq  = q_item.init_seq;
						res_d[0].ack  = q_item.s_inc;
						res_d[0].syn  = 1'b1;
						res_d[0].ackf = 1'b1;
						n_res         = CNT_W'(1);
					end
				end
				PH_HANDSHAKE: begin
					if (seq_match && ack_ok) begin
						own_seq_d      = q_item.ack[SEQ_W-1:0];
						own_inc_d      = a_inc;
						peer_d         = q_item.s_len;
						res_d[0].seq   = q_item.ack[SEQ_W-1:0];
						res_d[0].ack   = q_item.s_len;
						res_d[0].ackf  = 1'b1;
						res_d[0].store = 1'b1;
						res_d[0].bytes = q_item.len;
						n_res          = CNT_W'(1);
					end else if (q_item.syn) begin
						res_d[0].ack = peer_q;
						res_d[0].syn = 1'b1;
						res_d[0].dup = 1'b1;
						n_res        = CNT_W'(1);
					end
				end
				PH_DATA: begin
					if (seq_match) begin
						peer_d         = q_item.s_len;
						res_d[0].ack   = q_item.s_len;
						res_d[0].ackf  = 1'b1;
						res_d[0].store = 1'b1;
						res_d[0].bytes = q_item.len;
						n_res          = CNT_W'(1);
					end else if (!q_item.fin) begin
						if (ahead <= WIN_SPAN) begin
							res_d[0].ack = peer_q;
							res_d[0].dup = 1'b1;
						end else begin
							res_d[0].ack  = q_item.s_len;
							res_d[0].ackf = 1'b1;
						end
						n_res = CNT_W'(1);
					end
					if (q_item.fin) begin
						peer_d = fin_ack;
						retx_d = timeout_ticks;
						if (seq_match) begin
							res_d[1].ack  = fin_ack;
							res_d[1].ackf = 1'b1;
							res_d[2].fin  = 1'b1;
							n_res         = CNT_W'(3);
						end else begin
							res_d[0].ack  = fin_ack;
							res_d[0].ackf = 1'b1;
							res_d[1].fin  = 1'b1;
							n_res         = CNT_W'(2);
						end
					end
				end
				PH_CLOSING: begin
					if (q_item.fin) begin
						res_d[0].ack    = peer_q;
						res_d[0].dup    = 1'b1;
						res_d[1].fin    = 1'b1;
						res_d[1].resend = 1'b1;
						n_res           = CNT_W'(2);
						retx_d          = timeout_ticks;
					end else if (ack_ok) begin
						own_seq_d = q_item.ack[SEQ_W-1:0];
					end
				end
				default: n_res = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT_SYN;
			own_seq_q <= INIT_SEQ_RST;
			own_inc_q <= '0;
			peer_q    <= '0;
			retx_q    <= '0;
			rcnt_q    <= '0;
			ridx_q    <= '0;
		end else begin
			if (q_pop) begin
				phase_q   <= phase_d;
				own_seq_q <= own_seq_d;
				own_inc_q <= own_inc_d;
				peer_q    <= peer_d;
				retx_q    <= retx_d;
				rcnt_q    <= n_res;
				ridx_q    <= '0;
			end else if (m_valid && m_ready) begin
				rcnt_q <= rcnt_q - CNT_W'(1);
				ridx_q <= ridx_q + RIDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int k = 0; k < MAX_RES; k++) begin
				res_q[k] <= res_d[k];
			end
		end
	end

	always_comb begin
		case (ridx_q)
			2'd0:    m_res = res_q[0];
			2'd1:    m_res = res_q[1];
			default: m_res = res_q[2];
		endcase
	end

	assign m_valid = rcnt_q != '0;
	assign m_last  = rcnt_q == CNT_W'(1);

endmodule

/* sv/gbn_receiver_connection_fsm_unit.sv */
// top level of the go-back-n receiver connection unit with its register port
// a request passes the front pipeline and the queue, then the state machine registers
// its response headers; a request with n headers sends them as one run on m_axis
// the serializer loads one request per cycle, when idle or as its last header goes
// arst_n clears phase, sequence state, countdown, queue and front pipeline,
// and returns initial_seq to 0 and timeout_ticks to 500
`include "gbn_receiver_connection_fsm_unit_macros.svh"

module gbn_receiver_connection_fsm_unit
	import gcf_pkg::*;
#(
	parameter int SEQ_MODULUS    = SEQ_MODULUS_DEF,
	parameter int WINDOW_PACKETS = WINDOW_PACKETS_DEF,
	parameter int PAYLOAD_MAX    = PAYLOAD_MAX_DEF,
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pkt_seq, pkt_ack, pkt_syn, pkt_fin, pkt_ack_flag, pkt_dupack, pkt_length, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_seq, out_ack, out_syn, out_fin, out_ack_flag, out_dupack, out_resend,
	// out_timeout, store_payload, store_bytes, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [SEQ_W-1:0]  initial_seq_q;
	logic [TICK_W-1:0] timeout_ticks_q;
	logic              cfg_wr;
	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	logic              q_full;
	item_t             push_item;
	item_t             head_item;
	res_t              out_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_seq_q   <= INIT_SEQ_RST;
			timeout_ticks_q <= TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_INIT_SEQ: initial_seq_q   <= pwdata[SEQ_W-1:0];
				REG_TIMEOUT:  timeout_ticks_q <= pwdata[TICK_W-1:0];
				default:      initial_seq_q   <= initial_seq_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_INIT_SEQ: prdata = APB_DATA_W'(initial_seq_q);
			REG_TIMEOUT:  prdata = APB_DATA_W'(timeout_ticks_q);
			default:      prdata = '0;
		endcase
	end

	gcf_front #(
		.MODULUS     (SEQ_MODULUS),
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.DEPTH       (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.s_data      (s_axis_tdata),
		.s_mode      (s_axis_tuser),
		.initial_seq (initial_seq_q),
		.q_pop       (q_pop),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	gcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.valid     (q_valid),
		.full      (q_full),
		.head      (head_item)
	);

	gcf_back #(
		.MODULUS        (SEQ_MODULUS),
		.WINDOW_PACKETS (WINDOW_PACKETS),
		.PAYLOAD_MAX    (PAYLOAD_MAX)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.timeout_ticks (timeout_ticks_q),
		.m_valid       (m_axis_tvalid),
		.m_ready       (m_axis_tready),
		.m_res         (out_res),
		.m_last        (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_res.bytes, out_res.store, out_res.tmo, out_res.resend,
	                       out_res.dup, out_res.ackf, out_res.fin, out_res.syn,
	                       out_res.ack, out_res.seq};

	`GCF_ASSERT_SAME(a_queue_no_overflow, q_push, !q_full, "request queue written while full")
	`GCF_ASSERT_SAME(a_pop_needs_request, q_pop, q_valid, "state machine took from empty queue")
	`GCF_ASSERT_NEXT(a_run_unbroken, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid, "response run broken before its last header")

endmodule

/* bench/tb_gbn_receiver_connection_fsm_unit.sv */
// testbench of the go-back-n receiver connection unit: directed table, random traffic, header check
`timescale 1ns / 1ps

module tb_gbn_receiver_connection_fsm_unit;
	import gcf_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ADDR_INIT_SEQ = {REG_INIT_SEQ, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT  = {REG_TIMEOUT, 2'b00};
	localparam int WINDOW_SPAN = WINDOW_PACKETS_DEF * PAYLOAD_MAX_DEF;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic             mode;
		logic [NUM_W-1:0] seq;
		logic [NUM_W-1:0] ack;
		logic             syn;
		logic             fin;
		logic             ackf;
		logic             dup;
		logic [LEN_W-1:0] len;
	} rx_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] ack;
		logic             syn;
		logic             fin;
		logic             ackf;
		logic             dup;
		logic             resend;
		logic             tmo;
		logic             store;
		logic [LEN_W-1:0] bytes;
		logic             last;
	} tx_hdr_t;

	typedef struct packed {
		rx_item_t item;
		int       n_fixed;
		tx_hdr_t  hdr;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// model of the connection
	phase_t phase_now = PH_WAIT_SYN;
	int     own_seq = 0;
	int     peer_next = 0;
	int     syn_saved = 0;
	int     retx_left = 0;
	int     cfg_init_seq = int'(INIT_SEQ_RST);
	int     cfg_timeout = int'(TIMEOUT_RST);

	tx_hdr_t made_now[$];
	tx_hdr_t pending_headers[$];
	int      mismatch_count = 0;
	int      requests_taken = 0;
	int      headers_checked = 0;
	int      settings_used = 0;
	bit      calm = 0;
	bit      hold_go = 0;
	bit      hold_done = 0;

	dir_row_t dir_rows [24] = '{
		'{'{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 10'h3FF}, 0, '0},
		'{'{1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 10'h3FF}, 0, '0},
		'{'{1'b0, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 10'h3FF}, 1,
			'{15'd0, 15'd14334, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b1}},
		'{'{1'b0, 16'd5, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0}, 1,
			'{15'd0, 15'd14334, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, 1'b1}},
		'{'{1'b0, 16'd14334, 16'd5, 1'b0, 1'b0, 1'b1, 1'b0, 10'd7}, 0, '0},
		'{'{1'b0, 16'd14334, 16'd1, 1'b0, 1'b0, 1'b0, 1'b1, 10'h3FF}, 1,
			'{15'd1, 15'd14846, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 10'd512, 1'b1}},
		'{'{1'b0, 16'd14846, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'd14846, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 10'd511}, -1, '0},
		'{'{1'b0, 16'd20477, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd3}, -1, '0},
		'{'{1'b0, 16'd20478, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 10'd300}, -1, '0},
		'{'{1'b0, 16'd40958, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'h3FF}, -1, '0},
		'{'{1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'd15357, 16'd0, 1'b0, 1'b1, 1'b1, 1'b0, 10'd100}, -1, '0},
		'{'{1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'd9, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'd0, 16'd5, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'd0, 16'd2, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b0, 16'd1, 16'd1, 1'b0, 1'b0, 1'b1, 1'b0, 10'd512}, -1, '0},
		'{'{1'b0, 16'd7, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}, -1, '0},
		'{'{1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0}, -1, '0}
	};

	gbn_receiver_connection_fsm_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int wrap_add(input int a, input int b);
		return (a + b) % SEQ_MODULUS_DEF;
	endfunction

	function automatic tx_hdr_t make_header(input int seq, input int ack, input bit syn,
			input bit fin, input bit ackf, input bit dup, input bit resend, input bit tmo,
			input bit store, input int bytes);
		tx_hdr_t h;
		h = '{SEQ_W'(seq), SEQ_W'(ack), syn, fin, ackf, dup, resend, tmo, store,
			LEN_W'(bytes), 1'b0};
		return h;
	endfunction

	function automatic string show_header(input tx_hdr_t h);
		return {$sformatf("seq=%0d ack=%0d syn=%0b fin=%0b ackf=%0b dup=%0b ",
			h.seq, h.ack, h.syn, h.fin, h.ackf, h.dup),
			$sformatf("resend=%0b tmo=%0b store=%0b bytes=%0d last=%0b",
			h.resend, h.tmo, h.store, h.bytes, h.last)};
	endfunction

	// headers the unit answers to one request, state updated in place
	task automatic predict_headers(input rx_item_t it);
		int s;
		int a;
		int len;
		int d;
		made_now.delete();
		s = int'(it.seq);
		a = int'(it.ack);
		len = (int'(it.len) > PAYLOAD_MAX_DEF) ? PAYLOAD_MAX_DEF : int'(it.len);
		if (it.mode) begin
			if (phase_now == PH_CLOSING) begin
				if (retx_left <= 1) begin
					made_now.push_back(make_header(own_seq, 0, 0, 1, 0, 0, 1, 1, 0, 0));
					retx_left = cfg_timeout;
				end else begin
					retx_left--;
				end
			end
		end else begin
			case (phase_now)
				PH_WAIT_SYN: begin
					if (it.syn) begin
						own_seq = cfg_init_seq;
						syn_saved = s;
						peer_next = wrap_add(s, 1);
						made_now.push_back(make_header(own_seq, peer_next, 1, 0, 1, 0, 0, 0, 0, 0));
						phase_now = PH_HANDSHAKE;
					end
				end
				PH_HANDSHAKE: begin
					if (s == peer_next && (it.ackf || it.dup) && a == wrap_add(own_seq, 1)) begin
						own_seq = a & 32'h7FFF;
						peer_next = wrap_add(s, len);
						made_now.push_back(make_header(own_seq, peer_next, 0, 0, 1, 0, 0, 0, 1, len));
						phase_now = PH_DATA;
					end else if (it.syn) begin
						made_now.push_back(make_header(own_seq, wrap_add(syn_saved, 1),
							1, 0, 0, 1, 0, 0, 0, 0));
					end
				end
				PH_DATA: begin
					if (s == peer_next) begin
						peer_next = wrap_add(s, len);
						made_now.push_back(make_header(own_seq, peer_next, 0, 0, 1, 0, 0, 0, 1, len));
					end else if (!it.fin) begin
						d = (s % SEQ_MODULUS_DEF + SEQ_MODULUS_DEF - peer_next) % SEQ_MODULUS_DEF;
						if (d <= WINDOW_SPAN)
							made_now.push_back(make_header(own_seq, peer_next, 0, 0, 0, 1, 0, 0, 0, 0));
						else
							made_now.push_back(make_header(own_seq, wrap_add(s, len),
								0, 0, 1, 0, 0, 0, 0, 0));
					end
					if (it.fin) begin
						peer_next = wrap_add(peer_next, 1);
						made_now.push_back(make_header(own_seq, peer_next, 0, 0, 1, 0, 0, 0, 0, 0));
						made_now.push_back(make_header(own_seq, 0, 0, 1, 0, 0, 0, 0, 0, 0));
						retx_left = cfg_timeout;
						phase_now = PH_CLOSING;
					end
				end
				default: begin
					if (it.fin) begin
						made_now.push_back(make_header(own_seq, peer_next, 0, 0, 0, 1, 0, 0, 0, 0));
						made_now.push_back(make_header(own_seq, 0, 0, 1, 0, 0, 1, 0, 0, 0));
						retx_left = cfg_timeout;
					end else if ((it.ackf || it.dup) && a == wrap_add(own_seq, 1)) begin
						own_seq = a & 32'h7FFF;
						phase_now = PH_WAIT_SYN;
					end
				end
			endcase
		end
		if (made_now.size() > 0)
			made_now[made_now.size() - 1].last = 1'b1;
	endtask

	// mostly the request that moves the connection on, with random content, some noise
	function automatic rx_item_t next_request();
		rx_item_t it;
		int pick;
		it.mode = 1'b0;
		it.seq = NUM_W'($urandom);
		it.ack = NUM_W'($urandom);
		it.syn = 1'($urandom);
		it.fin = 1'($urandom);
		it.ackf = 1'($urandom);
		it.dup = 1'($urandom);
		it.len = ($urandom_range(99) < 15) ? LEN_W'(PAYLOAD_MAX_DEF) : LEN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 12) begin
			it.mode = 1'($urandom);
			return it;
		end
		case (phase_now)
			PH_WAIT_SYN: begin
				it.syn = 1'b1;
			end
			PH_HANDSHAKE: begin
				if (pick < 75) begin
					it.seq = NUM_W'(peer_next);
					it.ack = NUM_W'(wrap_add(own_seq, 1));
					if (!it.ackf && !it.dup)
						it.ackf = 1'b1;
				end else begin
					it.syn = 1'b1;
				end
			end
			PH_DATA: begin
				if (pick < 60) begin
					it.seq = NUM_W'(peer_next);
					it.fin = 1'b0;
				end else if (pick < 72) begin
					it.seq = NUM_W'(wrap_add(peer_next, $urandom_range(WINDOW_SPAN))
						+ ($urandom_range(1) ? SEQ_MODULUS_DEF : 0));
					it.fin = 1'b0;
				end else if (pick < 80) begin
					it.fin = 1'b0;
				end else if (pick < 90) begin
					it.fin = 1'b1;
					if ($urandom_range(1))
						it.seq = NUM_W'(peer_next);
				end else begin
					it.mode = 1'b1;
				end
			end
			default: begin
				if (pick < 55) begin
					it.mode = 1'b1;
				end else if (pick < 65) begin
					it.fin = 1'b1;
				end else if (pick < 85) begin
					it.fin = 1'b0;
					it.ack = NUM_W'(wrap_add(own_seq, 1));
					if (!it.ackf && !it.dup)
						it.dup = 1'b1;
				end else begin
					it.fin = 1'b0;
				end
			end
		endcase
		return it;
	endfunction

	task automatic send_request(input rx_item_t it, input int n_fixed, input tx_hdr_t fixed_hdr);
		if (!calm && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.mode;
		s_axis_tdata <= {2'b00, it.len, it.dup, it.ackf, it.fin, it.syn, it.ack, it.seq};
		do @(posedge clk); while (!s_axis_tready);
		requests_taken++;
		predict_headers(it);
		if (n_fixed < 0) begin
			foreach (made_now[k])
				pending_headers.push_back(made_now[k]);
		end else if (n_fixed > 0) begin
			pending_headers.push_back(fixed_hdr);
		end
	endtask

	task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_INIT_SEQ)
			cfg_init_seq = value & 32'h7FFF;
		else
			cfg_timeout = value & 32'hFFFF;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// unit idle: no request in flight, all headers back, pipeline drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_headers.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			m_axis_tready <= calm || $urandom_range(99) >= 24;
		end
	end

	always @(posedge clk) begin : check_headers
		tx_hdr_t got;
		tx_hdr_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[14:0], m_axis_tdata[29:15], m_axis_tdata[30], m_axis_tdata[31],
				m_axis_tdata[32], m_axis_tdata[33], m_axis_tdata[34], m_axis_tdata[35],
				m_axis_tdata[36], m_axis_tdata[46:37], m_axis_tlast};
			headers_checked++;
			if (pending_headers.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected header: expected none, actual %s", $time,
					show_header(got));
			end else begin
				want = pending_headers.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: header mismatch: expected %s", $time, show_header(want));
					$display("%0t: header mismatch: actual   %s", $time, show_header(got));
				end
			end
		end
	end

	initial begin
		int init_plan [5];
		int tick_plan [5];
		init_plan = '{25600, 0, $urandom_range(25600), 12345, $urandom_range(25600)};
		tick_plan = '{1, 3, 65535, $urandom_range(12, 2), $urandom_range(65535, 1)};
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero timeout: the fin goes out again on every tick
		write_register(ADDR_TIMEOUT, 0);
		settings_used++;
		foreach (dir_rows[i])
			send_request(dir_rows[i].item, dir_rows[i].n_fixed, dir_rows[i].hdr);

		for (int p = 0; p < 5; p++) begin
			settle();
			write_register(ADDR_INIT_SEQ, init_plan[p]);
			write_register(ADDR_TIMEOUT, tick_plan[p]);
			settings_used++;
			calm = (p == 1 || p == 3);
			if (p == 1) begin
				hold_go = 1'b1;
				while (!hold_done)
					send_request(next_request(), -1, '0);
			end
			repeat (60)
				send_request(next_request(), -1, '0);
		end
		calm = 1'b0;
		settle();

		$display("covered %0d requests and %0d response headers under %0d register settings,",
			requests_taken, headers_checked, settings_used);
		$display("including a long output stall that backed up the input side");
		if (mismatch_count == 0 && pending_headers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
